// ----- hw/rtl/ddo_pkg.sv -----
// Shared constants, register codes and the digit font for the decimal digit overlay.
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int unsigned FRAME_WIDTH  = 224;
  localparam int unsigned FRAME_HEIGHT = 172;
  localparam int unsigned CELL_PITCH   = 2;
  localparam int unsigned TEXT_ORIGIN  = 16;
  localparam int unsigned BLOCK_SIZE   = 5;
  localparam int unsigned MAX_DIGITS   = 10;

  localparam int unsigned GRID_COLS  = 4;
  localparam int unsigned GRID_ROWS  = 6;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_BITS   = 4 * BCD_DIGITS;

  localparam int unsigned VALUE_WIDTH = 31;
  localparam int unsigned LUMA_WIDTH  = 8;
  localparam int unsigned COORD_WIDTH = 8;
  localparam int unsigned STEP_WIDTH  = $clog2(VALUE_WIDTH + 1);

  localparam logic [LUMA_WIDTH-1:0] FORE_LUMA_RESET    = 8'd235;
  localparam logic [LUMA_WIDTH-1:0] BACK_LUMA_RESET    = 8'd16;
  localparam logic [LUMA_WIDTH-1:0] CHROMA_LEVEL_RESET = 8'd128;

  typedef enum logic [1:0] {
    REG_SHOWN_VALUE  = 2'd0,
    REG_FORE_LUMA    = 2'd1,
    REG_BACK_LUMA    = 2'd2,
    REG_CHROMA_LEVEL = 2'd3
  } cfg_reg_t;

  // one nibble per font row, bit 3 is column 0
  localparam logic [3:0] GLYPH [10][6] = '{
    '{4'hE, 4'hA, 4'hA, 4'hA, 4'hE, 4'h0},
    '{4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h0},
    '{4'hE, 4'h2, 4'hE, 4'h8, 4'hE, 4'h0},
    '{4'hE, 4'h2, 4'hE, 4'h2, 4'hE, 4'h0},
    '{4'hA, 4'hA, 4'hE, 4'h2, 4'h2, 4'h0},
    '{4'hE, 4'h8, 4'hE, 4'h2, 4'hE, 4'h0},
    '{4'hE, 4'h8, 4'hE, 4'hA, 4'hE, 4'h0},
    '{4'hE, 4'h2, 4'h2, 4'h2, 4'h2, 4'h0},
    '{4'hE, 4'hA, 4'hE, 4'hA, 4'hE, 4'h0},
    '{4'hE, 4'hA, 4'hE, 4'h2, 4'hE, 4'h0}
  };

  function automatic logic [3:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
    logic [3:0] bits;
    bits = 4'h0;
    if (digit <= 4'd9 && row <= 3'd5) begin
      bits = GLYPH[digit][row];
    end
    return bits;
  endfunction

endpackage

// ----- hw/rtl/ddo_bcd_conv.sv -----
// Shift-and-add-3 binary to decimal converter holding the drawn digits.
`timescale 1ns / 1ps

module ddo_bcd_conv #(
  parameter int unsigned MAX_DIGITS = ddo_pkg::MAX_DIGITS,
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ddo_pkg::VALUE_WIDTH-1:0]    value,
  output logic                               busy,
  output logic [CW-1:0]                      digit_count,
  output logic [MAX_DIGITS-1:0][3:0]         digits
);

  logic [ddo_pkg::BCD_BITS-1:0]    bcd;
  logic [ddo_pkg::BCD_BITS-1:0]    adj;
  logic [ddo_pkg::VALUE_WIDTH-1:0] shreg;
  logic [ddo_pkg::STEP_WIDTH-1:0]  step_cnt;
  logic [CW-1:0]                   digit_count_next;
  logic [MAX_DIGITS-1:0][3:0]      digits_next;

  always_comb begin
    for (int k = 0; k < int'(ddo_pkg::BCD_DIGITS); k++) begin
      adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
  end

  // significant digits, capped, most significant drawn digit at position 0
  always_comb begin
    int hi;
    hi = 0;
    for (int k = 0; k < int'(ddo_pkg::BCD_DIGITS); k++) begin
      if (bcd[4*k +: 4] != 4'd0) begin
        hi = k + 1;
      end
    end
    if (hi == 0) begin
      hi = 1;
    end
    if (hi > int'(MAX_DIGITS)) begin
      hi = int'(MAX_DIGITS);
    end
    digit_count_next = CW'(hi);
    for (int p = 0; p < int'(MAX_DIGITS); p++) begin
      digits_next[p] = 4'd0;
      for (int k = 0; k < int'(MAX_DIGITS); k++) begin
        if (k == hi - 1 - p) begin
          digits_next[p] = bcd[4*k +: 4];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step_cnt <= '0;
      bcd      <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      step_cnt <= ddo_pkg::STEP_WIDTH'(ddo_pkg::VALUE_WIDTH);
      bcd      <= '0;
    end else if (busy) begin
      bcd      <= {adj[ddo_pkg::BCD_BITS-2:0], shreg[ddo_pkg::VALUE_WIDTH-1]};
      step_cnt <= step_cnt - 1'b1;
      if (step_cnt == ddo_pkg::STEP_WIDTH'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
    end else if (busy) begin
      shreg <= {shreg[ddo_pkg::VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= CW'(1);
      digits      <= '0;
    end else begin
      digit_count <= digit_count_next;
      digits      <= digits_next;
    end
  end

endmodule

// ----- hw/rtl/ddo_glyph.sv -----
// Font lookup: finds the last font cell covering a pixel and returns its bit.
`timescale 1ns / 1ps

module ddo_glyph #(
  parameter int unsigned MAX_DIGITS = ddo_pkg::MAX_DIGITS,
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic [ddo_pkg::COORD_WIDTH-1:0] x,
  input  logic [ddo_pkg::COORD_WIDTH-1:0] y,
  input  logic [CW-1:0]                   digit_count,
  input  logic [MAX_DIGITS-1:0][3:0]      digits,
  output logic                            font
);

  localparam int unsigned NROW = ddo_pkg::GRID_ROWS;
  localparam int unsigned NCOL = ddo_pkg::GRID_COLS;

  logic [31:0]                      x_ext;
  logic [31:0]                      y_ext;
  logic                             in_frame;
  logic [NROW-1:0]                  row_hit;
  logic [NROW-1:0]                  row_sel;
  logic                             row_any;
  logic [MAX_DIGITS-1:0][NCOL-1:0]  col_hit;
  logic [MAX_DIGITS-1:0]            grp_any;
  logic [MAX_DIGITS-1:0]            grp_bit;

  assign x_ext    = 32'(x);
  assign y_ext    = 32'(y);
  assign in_frame = (x_ext < ddo_pkg::FRAME_WIDTH) && (y_ext < ddo_pkg::FRAME_HEIGHT);

  for (genvar i = 0; i < NROW; i++) begin : g_row
    localparam int unsigned Y0 = ddo_pkg::TEXT_ORIGIN + ddo_pkg::CELL_PITCH * i;
    assign row_hit[i] = (y_ext >= Y0) && (y_ext < Y0 + ddo_pkg::BLOCK_SIZE);
  end

  for (genvar p = 0; p < MAX_DIGITS; p++) begin : g_pos
    for (genvar c = 0; c < NCOL; c++) begin : g_col
      localparam int unsigned X0 =
        ddo_pkg::TEXT_ORIGIN + ddo_pkg::CELL_PITCH * (NCOL * p + c);
      assign col_hit[p][c] = (x_ext >= X0) && (x_ext < X0 + ddo_pkg::BLOCK_SIZE);
    end
  end

  // highest covering row
  always_comb begin
    row_sel = '0;
    row_any = 1'b0;
    for (int i = 0; i < int'(NROW); i++) begin
      if (row_hit[i]) begin
        row_sel = '0;
        row_sel[i] = 1'b1;
        row_any = 1'b1;
      end
    end
  end

  // per digit: font bit of its highest covering column in the chosen row
  always_comb begin
    logic [3:0] nib;
    logic       b;
    for (int p = 0; p < int'(MAX_DIGITS); p++) begin
      nib = 4'h0;
      for (int i = 0; i < int'(NROW); i++) begin
        if (row_sel[i]) begin
          nib = ddo_pkg::glyph_row(digits[p], 3'(i));
        end
      end
      b = 1'b0;
      for (int c = 0; c < int'(NCOL); c++) begin
        if (col_hit[p][c]) begin
          b = nib[NCOL-1-c];
        end
      end
      grp_bit[p] = b;
      grp_any[p] = (CW'(p) < digit_count) && (|col_hit[p]);
    end
  end

  always_comb begin
    font = 1'b0;
    for (int p = 0; p < int'(MAX_DIGITS); p++) begin
      if (grp_any[p]) begin
        font = grp_bit[p];
      end
    end
    font = font && in_frame && row_any;
  end

endmodule

// ----- hw/rtl/decimal_digit_overlay.sv -----
// Top level of the decimal digit overlay: config registers, pixel pipeline, result register.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+------------------------------------------
//   pixel    | pixel_valid / pixel_stall  | pixel_x, pixel_y
//   result   | result_valid / result_stall| luma_byte, chroma_byte, is_font_pixel
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One pixel per cycle while pixel_stall is low; each pixel beat passes the input register,
// then its result the output register. Writing shown_value starts a binary to decimal
// conversion; pixel_stall is high and cfg_ready low while it runs.
// Reset is synchronous; luma and chroma registers return to 235/16/128 and the value to 0.
// A stalled result holds the output register; the input register takes one more beat.
`timescale 1ns / 1ps

module decimal_digit_overlay #(
  parameter int unsigned MAX_DIGITS = ddo_pkg::MAX_DIGITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [ddo_pkg::COORD_WIDTH-1:0]   pixel_x,
  input  logic [ddo_pkg::COORD_WIDTH-1:0]   pixel_y,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [ddo_pkg::LUMA_WIDTH-1:0]    luma_byte,
  output logic [ddo_pkg::LUMA_WIDTH-1:0]    chroma_byte,
  output logic                              is_font_pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [ddo_pkg::VALUE_WIDTH-1:0]   cfg_data
);

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  logic [ddo_pkg::LUMA_WIDTH-1:0]  fore_luma;
  logic [ddo_pkg::LUMA_WIDTH-1:0]  back_luma;
  logic [ddo_pkg::LUMA_WIDTH-1:0]  chroma_level;
  logic                            cfg_wr;
  logic                            conv_start;
  logic                            conv_busy;
  logic [CW-1:0]                   digit_count;
  logic [MAX_DIGITS-1:0][3:0]      digits;

  logic                            s1_valid;
  logic [ddo_pkg::COORD_WIDTH-1:0] s1_x;
  logic [ddo_pkg::COORD_WIDTH-1:0] s1_y;
  logic                            out_open;
  logic                            pixel_take;
  logic                            font;

  assign cfg_ready  = !conv_busy;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign conv_start = cfg_wr && (ddo_pkg::cfg_reg_t'(cfg_index) == ddo_pkg::REG_SHOWN_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fore_luma    <= ddo_pkg::FORE_LUMA_RESET;
      back_luma    <= ddo_pkg::BACK_LUMA_RESET;
      chroma_level <= ddo_pkg::CHROMA_LEVEL_RESET;
    end else if (cfg_wr) begin
      unique case (ddo_pkg::cfg_reg_t'(cfg_index))
        ddo_pkg::REG_SHOWN_VALUE: begin
        end
        ddo_pkg::REG_FORE_LUMA:    fore_luma    <= cfg_data[ddo_pkg::LUMA_WIDTH-1:0];
        ddo_pkg::REG_BACK_LUMA:    back_luma    <= cfg_data[ddo_pkg::LUMA_WIDTH-1:0];
        ddo_pkg::REG_CHROMA_LEVEL: chroma_level <= cfg_data[ddo_pkg::LUMA_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  ddo_bcd_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk         (clk),
    .rst         (rst),
    .start       (conv_start),
    .value       (cfg_data),
    .busy        (conv_busy),
    .digit_count (digit_count),
    .digits      (digits)
  );

  assign out_open    = !result_valid || !result_stall;
  assign pixel_stall = conv_busy || (s1_valid && !out_open);
  assign pixel_take  = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_take) begin
      s1_valid <= 1'b1;
    end else if (out_open) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      s1_x <= pixel_x;
      s1_y <= pixel_y;
    end
  end

  ddo_glyph #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_glyph (
    .x           (s1_x),
    .y           (s1_y),
    .digit_count (digit_count),
    .digits      (digits),
    .font        (font)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_open) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s1_valid) begin
      luma_byte     <= font ? fore_luma : back_luma;
      chroma_byte   <= chroma_level;
      is_font_pixel <= font;
    end
  end

endmodule

// ----- hw/rtl/ddo_checker.sv -----
// Port-level checks for the decimal digit overlay, bound to the top level.
`timescale 1ns / 1ps

module ddo_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            pixel_stall,
  input logic                            result_valid,
  input logic                            result_stall,
  input logic [ddo_pkg::LUMA_WIDTH-1:0]  luma_byte,
  input logic [ddo_pkg::LUMA_WIDTH-1:0]  chroma_byte,
  input logic                            is_font_pixel,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [1:0]                      cfg_index
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(luma_byte) &&
      $stable(chroma_byte) && $stable(is_font_pixel))
    else $error("stalled result beat changed");

  a_value_write_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == ddo_pkg::REG_SHOWN_VALUE)
      |=> pixel_stall && !cfg_ready)
    else $error("value write did not start conversion");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !pixel_stall && cfg_ready)
    else $error("block not idle after reset");

endmodule

bind decimal_digit_overlay ddo_checker u_ddo_checker (
  .clk           (clk),
  .rst           (rst),
  .pixel_stall   (pixel_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .luma_byte     (luma_byte),
  .chroma_byte   (chroma_byte),
  .is_font_pixel (is_font_pixel),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_index     (cfg_index)
);
